// File: sv/ipdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP device table package
// Beat types, table entry layout, register indexes and shared constants.
// ----------------------------------------------------------------------------
package ipdt_pkg;

    localparam int MAX_DEVICES_DEF = 16;

    localparam int ADDR_W  = 32;
    localparam int SIL_W   = 8;
    localparam int AGE_W   = 17;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART    = 2'd1;

    localparam logic [SIL_W-1:0] DISCONNECT_RESET = 8'd10;
    localparam logic [15:0]      RESTART_RESET    = 16'd10000;
    localparam logic [SIL_W-1:0] SIL_MAX          = 8'hFF;
    localparam logic [CNT_W-1:0] CNT_MAX          = 5'd31;

    typedef enum logic [1:0] {
        OP_REPLY  = 2'd0,
        OP_TICK   = 2'd1,
        OP_LOOKUP = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] ip_address;
    } t_in_beat;

    typedef struct packed {
        logic              inserted;
        logic              found;
        logic [SLOT_W-1:0] slot_index;
        logic              table_full;
        logic [CNT_W-1:0]  removed_count;
        logic [CNT_W-1:0]  restarted_count;
    } t_out_beat;

    typedef struct packed {
        logic [ADDR_W-1:0] ip_address;
        logic [SIL_W-1:0]  silence;
        logic [AGE_W-1:0]  age;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// File: sv/ipdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP device table entry memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ipdt_ram #(
    parameter int WIDTH = ipdt_pkg::ENTRY_W,
    parameter int DEPTH = ipdt_pkg::MAX_DEVICES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    import ipdt_pkg::*;

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ip_keyed_device_table_with_aging_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP keyed device table with aging
// Table of network nodes keyed by IPv4 address, with silence and age counts.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one beat per operation: a reply from a device,
// an aging tick or a lookup. The output channel returns exactly one result
// beat for every input beat, in order. Configuration writes go through the
// plain write port; the user must make them only while the block is idle,
// and the block itself does not enforce this. Every operation walks all
// MAX_DEVICES entries of the entry RAM, one read a cycle, with the compare
// and write-back in the cycle after the read. A result is loaded into the
// output register once the walk ends, and the next input beat is taken only
// after that, so no new beat is accepted while an operation is in progress;
// the RAM read port sets this limit. Valid bits live in flip-flops and reset
// clears them at once, so no clearing pass is needed and the limits return to
// their defaults. The input channel stalls while reset is held.
// When the receiver stalls, the result waits in the output register; the
// next operation may walk meanwhile and holds in its final step until the
// register frees up.
// ----------------------------------------------------------------------------
module ip_keyed_device_table_with_aging_unit #(
    parameter int MAX_DEVICES = ipdt_pkg::MAX_DEVICES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ipdt_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ipdt_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [ipdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ipdt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import ipdt_pkg::*;

    localparam int IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_DEVICES - 1);

    t_state             r_state, n_state;
    logic [1:0]         r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_active;
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_idx;
    logic               r_cmp_last;
    logic [MAX_DEVICES-1:0] r_valid;
    logic               r_found;
    logic [IW-1:0]      r_match_idx;
    logic               r_free_vld;
    logic [IW-1:0]      r_free_idx;
    logic [CNT_W-1:0]   r_removed;
    logic [CNT_W-1:0]   r_restarted;
    logic               r_out_valid;
    t_out_beat          r_out;
    logic [SIL_W-1:0]   r_disc_lim;
    logic [15:0]        r_rst_lim;

    logic               in_ready;
    logic               in_fire;
    logic               fin_fire;
    t_entry             rd_entry;
    logic               hit;
    logic               addr_eq;
    logic               tick_remove;
    logic               tick_restart;
    t_entry             tick_entry;
    logic [AGE_W-1:0]   age_inc;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    t_entry             wr_data;
    logic               do_insert;
    t_out_beat          res;

    ipdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_DEVICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (r_rd_active),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_entry)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_cmp_vld && r_cmp_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        fin_fire = 1'b0;
        case (r_state)
            ST_IDLE:   in_ready = i_rst_n;
            ST_FINISH: fin_fire = !r_out_valid || !i_out_stall;
            default: begin
                in_ready = 1'b0;
                fin_fire = 1'b0;
            end
        endcase
    end

    assign in_fire = in_ready && i_in_valid;

    assign hit     = r_cmp_vld && r_valid[r_cmp_idx];
    assign addr_eq = (rd_entry.ip_address == r_addr);

    always_comb begin
        tick_entry   = rd_entry;
        tick_remove  = rd_entry.silence > r_disc_lim;
        tick_restart = 1'b0;
        age_inc      = rd_entry.age + 1'b1;
        if (rd_entry.silence != SIL_MAX) begin
            tick_entry.silence = rd_entry.silence + 1'b1;
        end
        tick_entry.age = age_inc;
        if (age_inc > {1'b0, r_rst_lim}) begin
            tick_restart       = 1'b1;
            tick_entry.silence = '0;
            tick_entry.age     = '0;
        end
    end

    assign do_insert = fin_fire && (r_op == OP_REPLY) && !r_found && r_free_vld;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cmp_idx;
        wr_data = rd_entry;
        if (hit) begin
            case (r_op)
                OP_REPLY: begin
                    if (addr_eq) begin
                        wr_en           = 1'b1;
                        wr_data.silence = '0;
                    end
                end
                OP_TICK: begin
                    if (!tick_remove) begin
                        wr_en   = 1'b1;
                        wr_data = tick_entry;
                    end
                end
                default: wr_en = 1'b0;
            endcase
        end
        if (do_insert) begin
            wr_en   = 1'b1;
            wr_addr = r_free_idx;
            wr_data = '{ip_address: r_addr, silence: '0, age: '0};
        end
    end

    always_comb begin
        res = '0;
        case (r_op)
            OP_REPLY: begin
                res.found      = r_found;
                res.inserted   = !r_found && r_free_vld;
                res.table_full = !r_found && !r_free_vld;
                if (r_found) begin
                    res.slot_index = SLOT_W'(r_match_idx);
                end else if (r_free_vld) begin
                    res.slot_index = SLOT_W'(r_free_idx);
                end
            end
            OP_TICK: begin
                res.removed_count   = r_removed;
                res.restarted_count = r_restarted;
            end
            OP_LOOKUP: begin
                res.found = r_found;
                if (r_found) begin
                    res.slot_index = SLOT_W'(r_match_idx);
                end
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_active <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_disc_lim  <= DISCONNECT_RESET;
            r_rst_lim   <= RESTART_RESET;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= r_rd_active;
            if (in_fire) begin
                r_rd_active <= 1'b1;
            end else if (r_rd_active && (r_rd_idx == LAST_IDX)) begin
                r_rd_active <= 1'b0;
            end
            if (hit && (r_op == OP_TICK) && tick_remove) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end
            if (do_insert) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISCONNECT: r_disc_lim <= i_cfg_wdata[SIL_W-1:0];
                    CFG_RESTART:    r_rst_lim  <= i_cfg_wdata;
                    default:        r_rst_lim  <= r_rst_lim;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= r_rd_idx;
        r_cmp_last <= r_rd_active && (r_rd_idx == LAST_IDX);
        if (fin_fire) begin
            r_out <= res;
        end
        if (in_fire) begin
            r_op        <= i_in_data.opcode;
            r_addr      <= i_in_data.ip_address;
            r_rd_idx    <= '0;
            r_found     <= 1'b0;
            r_match_idx <= '0;
            r_free_vld  <= 1'b0;
            r_free_idx  <= '0;
            r_removed   <= '0;
            r_restarted <= '0;
        end else begin
            if (r_rd_active) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_vld) begin
                r_free_vld <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            if (hit && addr_eq && !r_found
                    && ((r_op == OP_REPLY) || (r_op == OP_LOOKUP))) begin
                r_found     <= 1'b1;
                r_match_idx <= r_cmp_idx;
            end
            if (hit && (r_op == OP_TICK)) begin
                if (tick_remove) begin
                    r_removed <= sat_inc(r_removed);
                end else if (tick_restart) begin
                    r_restarted <= sat_inc(r_restarted);
                end
            end
        end
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/ipdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP device table port checker
// Concurrent checks on the top level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module ipdt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input ipdt_pkg::t_out_beat              o_out_data
);
    import ipdt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again before the walk started");

    a_reply_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.inserted && o_out_data.found)
                        && !(o_out_data.table_full
                             && (o_out_data.inserted || o_out_data.found)))
        else $error("conflicting reply flags");

    a_tick_only_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_data.removed_count != '0)
                         || (o_out_data.restarted_count != '0)))
        |-> (!o_out_data.found && !o_out_data.inserted && !o_out_data.table_full
             && (o_out_data.slot_index == '0)))
        else $error("tick counts mixed with lookup results");

endmodule

bind ip_keyed_device_table_with_aging_unit ipdt_checker u_ipdt_checker (.*);

// File: test/tb_ip_keyed_device_table_with_aging_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IP keyed device table with aging
// Sends replies, aging ticks, lookups and unused opcodes over the valid/stall
// channel and runs a behavioral copy of the table alongside the block. Each
// result beat is compared field by field, in order, against the copy's
// prediction or, for typed rows of the short directed table that comes first,
// against the row's own result. Random phases under several limit settings
// follow, with a long run of ticks that drives silence counts into saturation.
// ----------------------------------------------------------------------------
module tb_ip_keyed_device_table_with_aging_unit;
    import ipdt_pkg::*;

    localparam int NUM_SLOTS = MAX_DEVICES_DEF;
    localparam int POOL_SIZE = 20;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       reps;
        logic              typed;
        t_out_beat         result;
    } t_directed_row;

    localparam t_out_beat NONE = '0;

    t_directed_row directed_rows [16] = '{
        '{OP_LOOKUP, 32'h0000_0000, 16'd1,  1'b1, NONE},
        '{OP_REPLY,  32'h0000_0000, 16'd1,  1'b1, '{1'b1, 1'b0, 4'd0, 1'b0, 5'd0, 5'd0}},
        '{OP_REPLY,  32'hFFFF_FFFF, 16'd1,  1'b1, '{1'b1, 1'b0, 4'd1, 1'b0, 5'd0, 5'd0}},
        '{OP_REPLY,  32'h0000_0000, 16'd1,  1'b1, '{1'b0, 1'b1, 4'd0, 1'b0, 5'd0, 5'd0}},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 16'd1,  1'b1, '{1'b0, 1'b1, 4'd1, 1'b0, 5'd0, 5'd0}},
        '{OP_LOOKUP, 32'hFFFF_FFFE, 16'd1,  1'b1, NONE},
        '{OP_UNUSED, 32'h1234_5678, 16'd1,  1'b1, NONE},
        '{OP_TICK,   32'hFFFF_FFFF, 16'd1,  1'b1, NONE},
        '{OP_REPLY,  32'h8000_0001, 16'd1,  1'b1, '{1'b1, 1'b0, 4'd2, 1'b0, 5'd0, 5'd0}},
        '{OP_REPLY,  32'h0000_0001, 16'd1,  1'b1, '{1'b1, 1'b0, 4'd3, 1'b0, 5'd0, 5'd0}},
        '{OP_TICK,   32'h0000_0000, 16'd11, 1'b0, NONE},
        '{OP_REPLY,  32'h0000_0000, 16'd1,  1'b1, '{1'b1, 1'b0, 4'd0, 1'b0, 5'd0, 5'd0}},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 16'd1,  1'b1, NONE},
        '{OP_TICK,   32'h0000_0000, 16'd1,  1'b1, '{1'b0, 1'b0, 4'd0, 1'b0, 5'd2, 5'd0}},
        '{OP_LOOKUP, 32'h8000_0001, 16'd1,  1'b1, NONE},
        '{OP_LOOKUP, 32'h0000_0000, 16'd1,  1'b1, '{1'b0, 1'b1, 4'd0, 1'b0, 5'd0, 5'd0}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_beat              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_beat             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    logic              tbl_valid   [NUM_SLOTS];
    logic [ADDR_W-1:0] tbl_addr    [NUM_SLOTS];
    logic [SIL_W-1:0]  tbl_silence [NUM_SLOTS];
    logic [AGE_W-1:0]  tbl_age     [NUM_SLOTS];
    logic [SIL_W-1:0]  disconnect_limit;
    logic [15:0]       restart_limit;

    t_out_beat         expected_results [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    bit                idling_on;
    int                stall_left;
    int                quiet_cycles = 0;
    int                mismatches = 0;
    int n_reply = 0, n_tick = 0, n_lookup = 0, n_unused = 0;
    int n_insert = 0, n_full = 0, n_removed = 0, n_restarted = 0;

    ip_keyed_device_table_with_aging_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_beat table_step(input t_in_beat b);
        t_out_beat r;
        int        hit;
        int        free_slot;
        r = '0;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_valid[i] && tbl_addr[i] == b.ip_address && hit < 0) hit = i;
            if (!tbl_valid[i] && free_slot < 0) free_slot = i;
        end
        case (b.opcode)
            OP_REPLY: begin
                n_reply++;
                if (hit >= 0) begin
                    tbl_silence[hit] = '0;
                    r.found = 1'b1;
                    r.slot_index = SLOT_W'(hit);
                end else if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_addr[free_slot] = b.ip_address;
                    tbl_silence[free_slot] = '0;
                    tbl_age[free_slot] = '0;
                    r.inserted = 1'b1;
                    r.slot_index = SLOT_W'(free_slot);
                    n_insert++;
                end else begin
                    r.table_full = 1'b1;
                    n_full++;
                end
            end
            OP_TICK: begin
                n_tick++;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_silence[i] > disconnect_limit) begin
                            tbl_valid[i] = 1'b0;
                            r.removed_count++;
                        end else begin
                            if (tbl_silence[i] != SIL_MAX) tbl_silence[i]++;
                            tbl_age[i] = tbl_age[i] + 1'b1;
                            if (tbl_age[i] > restart_limit) begin
                                tbl_silence[i] = '0;
                                tbl_age[i] = '0;
                                r.restarted_count++;
                            end
                        end
                    end
                end
                n_removed += r.removed_count;
                n_restarted += r.restarted_count;
            end
            OP_LOOKUP: begin
                n_lookup++;
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot_index = SLOT_W'(hit);
                end
            end
            default: n_unused++;
        endcase
        return r;
    endfunction

    function automatic string show(input t_out_beat r);
        return $sformatf("ins=%0d found=%0d slot=%0d full=%0d removed=%0d restarted=%0d",
                         r.inserted, r.found, r.slot_index, r.table_full,
                         r.removed_count, r.restarted_count);
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        if (idling_on && stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling_on && !i_out_stall && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        string     bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                note_mismatch({"result beat with nothing expected: ", show(o_out_data)});
            end else begin
                want = expected_results.pop_front();
                bad = "";
                if (want.inserted !== o_out_data.inserted) bad = {bad, " inserted"};
                if (want.found !== o_out_data.found) bad = {bad, " found"};
                if (want.slot_index !== o_out_data.slot_index) bad = {bad, " slot_index"};
                if (want.table_full !== o_out_data.table_full) bad = {bad, " table_full"};
                if (want.removed_count !== o_out_data.removed_count)
                    bad = {bad, " removed_count"};
                if (want.restarted_count !== o_out_data.restarted_count)
                    bad = {bad, " restarted_count"};
                if (bad != "")
                    note_mismatch({"wrong", bad, "; expected ", show(want),
                                   "; got ", show(o_out_data)});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Timeout: no beat moved for %0d cycles.", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_beat(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input bit typed = 1'b0, input t_out_beat typed_result = '0);
        t_in_beat  b;
        t_out_beat predicted;
        b.opcode = op;
        b.ip_address = addr;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = table_step(b);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_DISCONNECT: disconnect_limit = data[SIL_W-1:0];
            CFG_RESTART:    restart_limit = data;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [SIL_W-1:0] disc, input logic [15:0] restart);
        drain();
        write_reg(CFG_DISCONNECT, {8'($urandom), disc});
        write_reg(CFG_RESTART, restart);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
    endtask

    task automatic run_phase(input logic [SIL_W-1:0] disc, input logic [15:0] restart,
                             input int items);
        int                pick;
        logic [ADDR_W-1:0] a;
        set_limits(disc, restart);
        foreach (addr_pool[k]) addr_pool[k] = $urandom;
        repeat (items) begin
            pick = $urandom_range(0, 99);
            a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 45) send_beat(OP_REPLY, a);
            else if (pick < 65) send_beat(OP_TICK, $urandom);
            else if (pick < 85) send_beat(OP_LOOKUP, a);
            else if (pick < 92) send_beat(OP_REPLY, $urandom);
            else if (pick < 97) send_beat(OP_LOOKUP, $urandom);
            else send_beat(OP_UNUSED, $urandom);
        end
    endtask

    function automatic logic [15:0] pick_restart();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    endfunction

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        stall_left = 0;
        idling_on = 1'b1;
        disconnect_limit = DISCONNECT_RESET;
        restart_limit = RESTART_RESET;
        foreach (tbl_valid[k]) begin
            tbl_valid[k] = 1'b0;
            tbl_addr[k] = '0;
            tbl_silence[k] = '0;
            tbl_age[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            repeat (directed_rows[r].reps)
                send_beat(directed_rows[r].op, directed_rows[r].addr,
                          directed_rows[r].typed, directed_rows[r].result);
        end

        run_phase(8'd0, 16'd0, 60);
        run_phase(8'd2, 16'd3, 80);
        run_phase(8'd254, 16'hFFFF, 60);

        // Silence counts must stop at their maximum rather than wrap, so a later
        // limit just below it still removes every entry.
        set_limits(8'd255, 16'hFFFF);
        foreach (addr_pool[k]) send_beat(OP_REPLY, addr_pool[k]);
        repeat (258) send_beat(OP_TICK, $urandom);
        set_limits(8'd254, 16'hFFFF);
        send_beat(OP_TICK, $urandom);
        send_beat(OP_LOOKUP, addr_pool[0]);

        repeat (4) run_phase(8'($urandom_range(0, 255)), pick_restart(), 50);
        idling_on = 1'b0;
        run_phase(8'($urandom_range(0, 255)), pick_restart(), 50);

        drain();
        repeat (30) @(posedge i_clk);
        $display("Covered %0d replies, %0d ticks, %0d lookups and %0d unused-opcode beats.",
                 n_reply, n_tick, n_lookup, n_unused);
        $display("The table took %0d inserts, refused %0d when full, removed %0d and cleared %0d.",
                 n_insert, n_full, n_removed, n_restarted);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
